[hw/rtl/mtd_pkg.sv]
// shared types and constants for the multichannel time debounce block
`default_nettype none

package mtd_pkg;

  localparam int unsigned CHANNELS = 16;
  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIMIT_W = 16;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_DEFAULT_MS = LIMIT_W'(30);

  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 8;
  localparam int unsigned M_USER_W = 1;

  // one sample handed to the channel state
  typedef struct packed {
    logic              en;
    logic [CH_W-1:0]   idx;
    logic              raw;
    logic [TIME_W-1:0] now;
  } upd_t;

endpackage

`default_nettype wire

[hw/rtl/multichannel_time_debounce_top.sv]
// top level of the multichannel time debounce block
//
// usage:
//   s_axis carries one sample word: channel, raw level and a wrapping
//   millisecond timestamp. m_axis returns one word per sample: the
//   channel's debounced level in tdata and an invalid-channel flag in
//   tuser (level reads 0 when the flag is set, and no state changes).
//   cfg_valid_i/cfg_data_i write the debounce time in ms; a value of 0
//   acts as the 30 ms default. write it only while no word is in flight.
// timing:
//   a sample is registered on accept and its result is registered
//   when the output register advances; one sample per cycle is
//   sustained while m_axis_tready is high. the channel state is
//   updated in the same cycle the sample moves to the output register,
//   so samples of the same channel may follow back to back.
// reset: all channels return to the not-started state, debounce time
//   returns to 30 ms, both pipeline registers are emptied.
// stall: with m_axis_tready low the output word holds; one more sample
//   is taken into the input register, then s_axis_tready drops.
`default_nettype none

module multichannel_time_debounce_top
  import mtd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [7:0] channel, [8] raw_level, [40:9] now_ms, [47:41] zero
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] level, [7:1] zero
  output logic [M_DATA_W-1:0]      m_axis_tdata,
  // [0] invalid_channel
  output logic [M_USER_W-1:0]      m_axis_tuser,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [LIMIT_W-1:0]  cfg_data_i
);

  logic [LIMIT_W-1:0] debounce_q, limit;

  logic              in_valid_q;
  logic [CHAN_W-1:0] in_chan_q;
  logic              in_raw_q;
  logic [TIME_W-1:0] in_now_q;

  logic out_valid_q, out_level_q, out_inv_q;
  logic advance, in_take, chan_ok, level;
  upd_t upd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_DEFAULT_MS;
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  assign limit = (debounce_q == '0) ? DEBOUNCE_DEFAULT_MS : debounce_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_chan_q <= s_axis_tdata[CHAN_W-1:0];
      in_raw_q  <= s_axis_tdata[CHAN_W];
      in_now_q  <= s_axis_tdata[CHAN_W+TIME_W:CHAN_W+1];
    end
  end

  assign chan_ok = ({1'b0, in_chan_q} < (CHAN_W+1)'(CHANNELS));

  always_comb begin
    upd.en  = in_valid_q && advance && chan_ok;
    upd.idx = in_chan_q[CH_W-1:0];
    upd.raw = in_raw_q;
    upd.now = in_now_q;
  end

  mtd_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .limit_i (limit),
    .level_o (level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_level_q <= chan_ok && level;
      out_inv_q   <= !chan_ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_DATA_W-1){1'b0}}, out_level_q};
  assign m_axis_tuser  = out_inv_q;

endmodule

`default_nettype wire

[hw/rtl/mtd_state.sv]
// per-channel debounce state with combinational read and registered write-back
`default_nettype none

module mtd_state
  import mtd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire upd_t               upd_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  output logic                    level_o
);

  logic              started_q [CHANNELS];
  logic              stable_q  [CHANNELS];
  logic              cand_q    [CHANNELS];
  logic [TIME_W-1:0] since_q   [CHANNELS];

  logic              cur_stable, cur_cand;
  logic [TIME_W-1:0] cur_since, elapsed;
  logic              stable_d, cand_d;
  logic [TIME_W-1:0] since_d;

  always_comb begin
    // a channel never seen takes the raw level and the current time
    if (started_q[upd_i.idx]) begin
      cur_stable = stable_q[upd_i.idx];
      cur_cand   = cand_q[upd_i.idx];
      cur_since  = since_q[upd_i.idx];
    end else begin
      cur_stable = upd_i.raw;
      cur_cand   = upd_i.raw;
      cur_since  = upd_i.now;
    end
    elapsed  = upd_i.now - cur_since;
    stable_d = cur_stable;
    cand_d   = cur_cand;
    since_d  = cur_since;
    if (upd_i.raw != cur_cand) begin
      cand_d  = upd_i.raw;
      since_d = upd_i.now;
    end else if (elapsed >= TIME_W'(limit_i)) begin
      stable_d = cur_cand;
    end
  end

  assign level_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        started_q[i] <= 1'b0;
        stable_q[i]  <= 1'b0;
        cand_q[i]    <= 1'b0;
      end
    end else if (upd_i.en) begin
      started_q[upd_i.idx] <= 1'b1;
      stable_q[upd_i.idx]  <= stable_d;
      cand_q[upd_i.idx]    <= cand_d;
    end
  end

  // timestamps are only read once the channel has started
  always_ff @(posedge clk_i) begin
    if (upd_i.en) begin
      since_q[upd_i.idx] <= since_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mtd_checker.sv]
// port-level checks for the multichannel time debounce block
`default_nettype none

module mtd_checker
  import mtd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [M_DATA_W-1:0] m_axis_tdata,
  input wire logic [M_USER_W-1:0] m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a bad channel always reads level low
  a_invalid_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("invalid channel reported a high level");

  // with the output side empty the input side never blocks
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind multichannel_time_debounce_top mtd_checker u_mtd_checker (.*);

`default_nettype wire
